>>> design/lhm_pkg.sv
package lhm_pkg;

    localparam int NUM_STREAMS = 8;
    localparam int MAX_BUCKETS = 16;
    localparam int STREAM_W    = 3;
    localparam int BKT_W       = 4;
    localparam int ADDR_W      = STREAM_W + BKT_W;
    localparam int HIST_DEPTH  = NUM_STREAMS * MAX_BUCKETS;

    localparam int DVD_W = 63;
    localparam int DVS_W = 32;

    // configuration register indexes
    localparam logic [1:0] CFG_BUCKET_COUNT = 2'd0;
    localparam logic [1:0] CFG_BUCKET_WIDTH = 2'd1;
    localparam logic [1:0] CFG_RESET_PERIOD = 2'd2;

    localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;
    localparam logic [62:0] MAX63 = 63'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DVD_W-1:0] quotient;
    } div_rsp_t;

endpackage

>>> design/lhm_div.sv
module lhm_div (
    input  logic             aclk,
    input  logic             aresetn,
    input  lhm_pkg::div_req_t req,
    output lhm_pkg::div_rsp_t rsp
);
    import lhm_pkg::*;

    logic [DVD_W-1:0] quo_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [5:0]       cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DVS_W:0]   shifted;
    logic [DVS_W:0]   diff;
    logic             ge;

    // one restoring step per cycle, quotient bits shift in from the bottom
    assign shifted = {rem_reg, quo_reg[DVD_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign ge      = shifted >= {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                quo_reg  <= req.dividend;
                dvs_reg  <= req.divisor;
                rem_reg  <= '0;
            end else if (busy_reg) begin
                rem_reg <= ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
                quo_reg <= {quo_reg[DVD_W-2:0], ge};
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'(DVD_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

    // checks
    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |-> !busy_reg)
        else $error("divider started while busy");

    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg)
        else $error("divider done while still busy");

    a_done_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |=> !done_reg)
        else $error("divider done held longer than one cycle");

endmodule

>>> design/latency_histogram_monitor.sv
// Sequence: a packet event passes PREP, then LDIV for its bucket index (in the shared
// one-bit-per-cycle 63-bit divider), then SCAN for each stream skipped and SCAN, RD,
// RMW, AVG and EMIT per stream in its mask, AVG being the average division; a read
// passes RRD, RDAT, AVG (WAIT if the stream count is 0), EMIT. Output stalls hold EMIT.
// Throughput: one item at a time; the next is taken once the last result is loaded.
// Reset (aresetn, synchronous, low): config defaults, start state, sums, counts, valids.
module latency_histogram_monitor (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // time_now[47:0], packet_timestamp[95:48], stream_mask[103:96],
    // read_stream[106:104], read_bucket[110:107], zero pad
    input  logic [111:0] s_tdata,
    // mode[0], ref_present[1]
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // stream_index[2:0], latency_usec[50:3], avg_latency_usec[98:51],
    // sum_latency_usec[161:99], bucket_index[165:162], bucket_value[197:166], pad
    output logic [199:0] m_tdata,
    output logic         m_tlast,
    input  logic         cfg_wr_en,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_wdata
);
    import lhm_pkg::*;

    typedef enum logic [10:0] {
        ST_IDLE = 11'b00000000001,
        ST_PREP = 11'b00000000010,
        ST_LDIV = 11'b00000000100,
        ST_SCAN = 11'b00000001000,
        ST_RD   = 11'b00000010000,
        ST_RMW  = 11'b00000100000,
        ST_AVG  = 11'b00001000000,
        ST_EMIT = 11'b00010000000,
        ST_RRD  = 11'b00100000000,
        ST_RDAT = 11'b01000000000,
        ST_WAIT = 11'b10000000000
    } state_t;

    state_t state_reg;

    // config
    logic [4:0]  nb_cfg_reg;
    logic [31:0] width_cfg_reg;
    logic [31:0] period_cfg_reg;

    // captured item
    logic               mode_reg;
    logic               ref_reg;
    logic [47:0]        now_reg;
    logic signed [47:0] pkt_reg;
    logic [7:0]         mask_reg;
    logic [STREAM_W-1:0] rs_reg;
    logic [BKT_W-1:0]   rb_reg;

    // monitor state
    logic               started_reg;
    logic [47:0]        fct_reg;
    logic signed [47:0] fref_reg;
    logic [47:0]        lct_reg;
    logic [62:0]        sums_reg [NUM_STREAMS];
    logic [31:0]        cnts_reg [NUM_STREAMS];

    // histogram store with one valid bit per entry
    logic [31:0]         hist_mem [HIST_DEPTH];
    logic [HIST_DEPTH-1:0] hist_vld_reg;
    logic [ADDR_W-1:0]   hist_addr_reg;
    logic [31:0]         rd_data_reg;
    logic                rd_vld_reg;
    logic                mem_rd;
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_rd_addr;

    // work registers
    logic [47:0]         lat_reg;
    logic [BKT_W-1:0]    bkt_reg;
    logic [STREAM_W-1:0] s_reg;
    logic [31:0]         bv_reg;
    logic [62:0]         sum_out_reg;
    logic [47:0]         avg_reg;

    // output register
    logic         m_tvalid_reg;
    logic [199:0] m_tdata_reg;
    logic         m_tlast_reg;

    div_req_t div_req;
    div_rsp_t div_rsp;

    lhm_div u_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .req    (div_req),
        .rsp    (div_rsp)
    );

    // prep-stage arithmetic
    logic [47:0]        eff_fct;
    logic signed [47:0] eff_fref;
    logic [47:0]        eff_lct;
    logic signed [48:0] elapsed;
    logic               clr_due;
    logic signed [50:0] slat;
    logic [47:0]        lat_sat;
    logic [4:0]         nb_eff;
    logic [31:0]        width_eff;
    logic [BKT_W-1:0]   bkt_calc;
    logic [31:0]        hist_cur;
    logic [31:0]        hist_new;
    logic [63:0]        sum_wide;
    logic [62:0]        sum_new;
    logic [31:0]        cnt_new;
    logic [7:0]         mask_above;
    logic               walk_last;
    logic               out_free;
    logic [47:0]        avg_clamp;

    assign eff_fct  = started_reg ? fct_reg  : now_reg;
    assign eff_fref = started_reg ? fref_reg : pkt_reg;
    assign eff_lct  = started_reg ? lct_reg  : now_reg;
    assign elapsed  = $signed({1'b0, now_reg}) - $signed({1'b0, eff_lct});
    assign clr_due  = (period_cfg_reg != '0) &&
                      (elapsed >= $signed({17'b0, period_cfg_reg}));
    assign slat = $signed({3'b0, now_reg}) - $signed({3'b0, eff_fct})
                + 51'(eff_fref) - 51'(pkt_reg);
    assign lat_sat = (slat[49:48] != 2'b00) ? MAX48 : slat[47:0];

    assign nb_eff = (nb_cfg_reg == 5'd0) ? 5'd1 :
                    (nb_cfg_reg > 5'(MAX_BUCKETS)) ? 5'(MAX_BUCKETS) : nb_cfg_reg;
    assign width_eff = (width_cfg_reg == '0) ? 32'd1 : width_cfg_reg;
    assign bkt_calc  = (div_rsp.quotient >= 63'(nb_eff)) ? BKT_W'(nb_eff - 5'd1)
                                                          : div_rsp.quotient[BKT_W-1:0];

    // read-modify-write values
    assign hist_cur = rd_vld_reg ? rd_data_reg : '0;
    assign hist_new = (hist_cur == MAX32) ? hist_cur : hist_cur + 32'd1;
    assign sum_wide = {1'b0, sums_reg[s_reg]} + {16'b0, lat_reg};
    assign sum_new  = (sum_wide > {1'b0, MAX63}) ? MAX63 : sum_wide[62:0];
    assign cnt_new  = (cnts_reg[s_reg] == MAX32) ? MAX32 : cnts_reg[s_reg] + 32'd1;

    assign mask_above = mask_reg >> s_reg;
    assign walk_last  = (mask_above[7:1] == 7'd0);
    assign out_free   = !m_tvalid_reg || m_tready;
    assign avg_clamp  = (div_rsp.quotient > {15'b0, MAX48}) ? MAX48
                                                            : div_rsp.quotient[47:0];

    assign s_tready = (state_reg == ST_IDLE);
    assign mem_rd   = (state_reg == ST_RD) || (state_reg == ST_RRD);
    assign mem_we   = (state_reg == ST_RMW);

    // read address: requested entry in read mode, else stream and bucket of the walk
    assign mem_rd_addr = (state_reg == ST_RRD) ? {rs_reg, rb_reg} : {s_reg, bkt_reg};

    // divider requests
    always_comb begin
        div_req = '0;
        unique case (state_reg)
            ST_PREP: begin
                div_req.start    = (started_reg || ref_reg) && !slat[50];
                div_req.dividend = {15'b0, lat_sat};
                div_req.divisor  = width_eff;
            end
            ST_RMW: begin
                div_req.start    = 1'b1;
                div_req.dividend = sum_new;
                div_req.divisor  = cnt_new;
            end
            ST_RDAT: begin
                div_req.start    = (cnts_reg[rs_reg] != '0);
                div_req.dividend = sums_reg[rs_reg];
                div_req.divisor  = cnts_reg[rs_reg];
            end
            default: div_req = '0;
        endcase
    end

    // config writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nb_cfg_reg     <= 5'd10;
            width_cfg_reg  <= 32'd10000;
            period_cfg_reg <= 32'd0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_BUCKET_COUNT: nb_cfg_reg     <= cfg_wdata[4:0];
                CFG_BUCKET_WIDTH: width_cfg_reg  <= cfg_wdata;
                CFG_RESET_PERIOD: period_cfg_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // histogram memory, registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            hist_mem[hist_addr_reg] <= hist_new;
        end
        if (mem_rd) begin
            rd_data_reg <= hist_mem[mem_rd_addr];
        end
    end

    // control sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            started_reg  <= 1'b0;
            fct_reg      <= '0;
            fref_reg     <= '0;
            lct_reg      <= '0;
            hist_vld_reg <= '0;
            rd_vld_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < NUM_STREAMS; i++) begin
                sums_reg[i] <= '0;
                cnts_reg[i] <= '0;
            end
        end else begin
            // output valid: load on emit, drop once taken
            if (state_reg == ST_EMIT && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (mem_rd) begin
                hist_addr_reg <= mem_rd_addr;
                rd_vld_reg    <= hist_vld_reg[mem_rd_addr];
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        mode_reg  <= s_tuser[0];
                        ref_reg   <= s_tuser[1];
                        now_reg   <= s_tdata[47:0];
                        pkt_reg   <= s_tdata[95:48];
                        mask_reg  <= s_tdata[103:96];
                        rs_reg    <= s_tdata[106:104];
                        rb_reg    <= s_tdata[110:107];
                        state_reg <= s_tuser[0] ? ST_RRD : ST_PREP;
                    end
                end
                ST_PREP: begin
                    if (!started_reg && !ref_reg) begin
                        state_reg <= ST_IDLE;
                    end else begin
                        started_reg <= 1'b1;
                        fct_reg     <= eff_fct;
                        fref_reg    <= eff_fref;
                        lct_reg     <= clr_due ? now_reg : eff_lct;
                        if (clr_due) begin
                            hist_vld_reg <= '0;
                            for (int i = 0; i < NUM_STREAMS; i++) begin
                                sums_reg[i] <= '0;
                                cnts_reg[i] <= '0;
                            end
                        end
                        lat_reg   <= lat_sat;
                        state_reg <= slat[50] ? ST_IDLE : ST_LDIV;
                    end
                end
                ST_LDIV: begin
                    if (div_rsp.done) begin
                        bkt_reg   <= bkt_calc;
                        s_reg     <= '0;
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (mask_reg[s_reg]) begin
                        state_reg <= ST_RD;
                    end else if (s_reg == STREAM_W'(NUM_STREAMS - 1)) begin
                        state_reg <= ST_IDLE;
                    end else begin
                        s_reg <= s_reg + 1'b1;
                    end
                end
                ST_RD: begin
                    state_reg <= ST_RMW;
                end
                ST_RMW: begin
                    hist_vld_reg[hist_addr_reg] <= 1'b1;
                    sums_reg[s_reg] <= sum_new;
                    cnts_reg[s_reg] <= cnt_new;
                    bv_reg          <= hist_new;
                    sum_out_reg     <= sum_new;
                    state_reg       <= ST_AVG;
                end
                ST_AVG: begin
                    if (div_rsp.done) begin
                        avg_reg   <= avg_clamp;
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        m_tlast_reg  <= mode_reg || walk_last;
                        m_tdata_reg  <= {2'b00, bv_reg, bkt_reg, sum_out_reg,
                                         avg_reg, lat_reg, s_reg};
                        if (mode_reg || walk_last ||
                            s_reg == STREAM_W'(NUM_STREAMS - 1)) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            s_reg     <= s_reg + 1'b1;
                            state_reg <= ST_SCAN;
                        end
                    end
                end
                ST_RRD: begin
                    state_reg <= ST_RDAT;
                end
                ST_RDAT: begin
                    bv_reg      <= rd_vld_reg ? rd_data_reg : '0;
                    sum_out_reg <= sums_reg[rs_reg];
                    lat_reg     <= '0;
                    bkt_reg     <= rb_reg;
                    s_reg       <= rs_reg;
                    avg_reg     <= '0;
                    state_reg   <= (cnts_reg[rs_reg] != '0) ? ST_AVG : ST_WAIT;
                end
                ST_WAIT: begin
                    state_reg <= ST_EMIT;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // checks
    a_idle_div_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !div_rsp.busy)
        else $error("divider busy while idle");

    a_write_after_read: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> $past(state_reg) == ST_RD)
        else $error("histogram write without preceding read");

    a_emit_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && out_free) |=> m_tvalid_reg)
        else $error("result not loaded");

    a_wait_for_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_AVG && !div_rsp.done) |-> div_rsp.busy)
        else $error("waiting on idle divider");

endmodule
